// ===== hw/rtl/rgcc_pkg.sv =====
`default_nettype none

package rgcc_pkg;

    localparam int PIX_W   = 16;
    localparam int GRAY_W  = 8;
    localparam int COORD_W = 10;
    localparam int SUM_W   = 13;
    localparam int COEF_W  = 5;
    localparam int KSEL_W  = 3;
    localparam int IWID_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_KERNELS = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SELECT = 1'd1;

    localparam logic [KSEL_W-1:0] KSEL_IDENTITY = 3'd0;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_V  = 3'd1;
    localparam logic [KSEL_W-1:0] KSEL_SOBEL_H  = 3'd2;
    localparam logic [KSEL_W-1:0] KSEL_EDGES    = 3'd3;
    localparam logic [KSEL_W-1:0] KSEL_SHARPEN  = 3'd4;
    localparam logic [KSEL_W-1:0] KSEL_CROSS    = 3'd5;

    localparam logic [10:0] IMAGE_WIDTH_RESET = 11'd320;

    // divide by 3 as (x * 683) >> 11, exact for x below 2048
    localparam logic [10:0] GRAY_RECIP = 11'd683;
    localparam int          GRAY_SHIFT = 11;

    localparam logic [GRAY_W-1:0] CLAMP_MAX = 8'd255;

    localparam logic signed [COEF_W-1:0] KERNEL_TAB [NUM_KERNELS][NUM_TAPS] = '{
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
        '{ 5'sd1,  5'sd0, -5'sd1,  5'sd2,  5'sd0, -5'sd2,  5'sd1,  5'sd0, -5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd0,  5'sd0, -5'sd1, -5'sd2, -5'sd1},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
        '{-5'sd1,  5'sd1, -5'sd1,  5'sd1,  5'sd0,  5'sd1, -5'sd1,  5'sd1, -5'sd1}
    };

    typedef struct packed {
        logic [GRAY_W-1:0] upper;
        logic [GRAY_W-1:0] middle;
        logic [GRAY_W-1:0] gray;
    } column_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
    } stage_ctrl_t;

    // coefficient times tap with shifts and adds only
    function automatic logic signed [SUM_W-1:0] tap_term(
        input logic signed [COEF_W-1:0] c,
        input logic [GRAY_W-1:0]        v
    );
        logic signed [SUM_W-1:0] sv;
        logic signed [SUM_W-1:0] r;
        sv = $signed({{(SUM_W-GRAY_W){1'b0}}, v});
        case (c)
            5'sd1:   r = sv;
            -5'sd1:  r = -sv;
            5'sd2:   r = sv <<< 1;
            -5'sd2:  r = -(sv <<< 1);
            5'sd5:   r = (sv <<< 2) + sv;
            5'sd8:   r = sv <<< 3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rgcc_if.sv =====
`default_nettype none

interface rgcc_pix_if;
    logic                          valid;
    logic                          ready;
    logic [rgcc_pkg::PIX_W-1:0]    pixel_rgb565;
    logic                          frame_start;

    modport source (output valid, output pixel_rgb565, output frame_start, input ready);
    modport sink   (input valid, input pixel_rgb565, input frame_start, output ready);
endinterface

interface rgcc_res_if;
    logic                          valid;
    logic                          ready;
    logic [rgcc_pkg::GRAY_W-1:0]   filtered_value;
    logic [rgcc_pkg::COORD_W-1:0]  out_col;
    logic [rgcc_pkg::COORD_W-1:0]  out_row;

    modport source (output valid, output filtered_value, output out_col, output out_row,
                    input ready);
    modport sink   (input valid, input filtered_value, input out_col, input out_row,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rgcc_conv.sv =====
`default_nettype none

module rgcc_conv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          shift,
    input  wire rgcc_pkg::column_t             column,
    input  wire rgcc_pkg::stage_ctrl_t         ctrl_in,
    input  wire logic [rgcc_pkg::KSEL_W-1:0]   kernel_select,
    output rgcc_pkg::stage_ctrl_t              ctrl_out,
    output logic [rgcc_pkg::GRAY_W-1:0]        value
);

    logic [rgcc_pkg::GRAY_W-1:0]        taps_reg [rgcc_pkg::NUM_TAPS];
    logic signed [rgcc_pkg::SUM_W-1:0]  rsum_reg [3];
    logic signed [rgcc_pkg::SUM_W-1:0]  rsum_next [3];
    rgcc_pkg::stage_ctrl_t              s2_reg;
    rgcc_pkg::stage_ctrl_t              s3_reg;
    logic [rgcc_pkg::KSEL_W-1:0]        ksel;
    logic signed [rgcc_pkg::SUM_W-1:0]  total;

    always_ff @(posedge clk)
    begin
        if (adv && shift)
        begin
            taps_reg[0] <= taps_reg[1];
            taps_reg[1] <= taps_reg[2];
            taps_reg[2] <= column.upper;
            taps_reg[3] <= taps_reg[4];
            taps_reg[4] <= taps_reg[5];
            taps_reg[5] <= column.middle;
            taps_reg[6] <= taps_reg[7];
            taps_reg[7] <= taps_reg[8];
            taps_reg[8] <= column.gray;
        end
    end

    assign ksel = (kernel_select > rgcc_pkg::KSEL_CROSS) ? rgcc_pkg::KSEL_IDENTITY
                                                         : kernel_select;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rsum_next[r] = rgcc_pkg::tap_term(rgcc_pkg::KERNEL_TAB[ksel][3*r],   taps_reg[3*r])
                         + rgcc_pkg::tap_term(rgcc_pkg::KERNEL_TAB[ksel][3*r+1], taps_reg[3*r+1])
                         + rgcc_pkg::tap_term(rgcc_pkg::KERNEL_TAB[ksel][3*r+2], taps_reg[3*r+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rsum_reg[r] <= rsum_next[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg <= ctrl_in;
            s3_reg <= s2_reg;
        end
    end

    assign total = rsum_reg[0] + rsum_reg[1] + rsum_reg[2];

    always_comb
    begin
        if (total < 0)
        begin
            value = '0;
        end
        else if (total > $signed({{(rgcc_pkg::SUM_W-rgcc_pkg::GRAY_W){1'b0}},
                                  rgcc_pkg::CLAMP_MAX}))
        begin
            value = rgcc_pkg::CLAMP_MAX;
        end
        else
        begin
            value = total[rgcc_pkg::GRAY_W-1:0];
        end
    end

    assign ctrl_out = s3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb565_gray_conv3x3_clamp.sv =====
`default_nettype none
// channel   dir  fields                                   width
// pix       in   pixel_rgb565, frame_start                16, 1
// res       out  filtered_value, out_col, out_row         8, 10, 10
// cfg       in   cfg_we, cfg_index, cfg_data              1, 1, 11
//
// one pixel per cycle sustained unless a result waits on res.ready; a taken pixel
// passes the stage 1, tap and row-sum registers and then the output register
// the line store is one memory with one read and one write port, read at accept
// and written back from stage 1, with forwarding when the same column follows
// reset clears counters and valids and loads the default configuration; the line store is not cleared
// the whole pipeline holds while a result waits on res.ready

module rgb565_gray_conv3x3_clamp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rgcc_pix_if.sink                               pix,
    rgcc_res_if.source                             res,
    input  wire logic                              cfg_we,
    input  wire logic [rgcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rgcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMP_W = (COL_W + 1 > rgcc_pkg::IWID_W) ? COL_W + 1 : rgcc_pkg::IWID_W;
    localparam int CX_W  = (COL_W > rgcc_pkg::COORD_W) ? COL_W : rgcc_pkg::COORD_W;
    localparam int RX_W  = (ROW_W > rgcc_pkg::COORD_W) ? ROW_W : rgcc_pkg::COORD_W;
    localparam int LS_W  = 2 * rgcc_pkg::GRAY_W;

    logic [rgcc_pkg::IWID_W-1:0]   width_reg;
    logic [rgcc_pkg::KSEL_W-1:0]   ksel_reg;
    logic [COL_W-1:0]              col_reg;
    logic [ROW_W-1:0]              row_reg;

    logic                          adv;
    logic                          acc;
    logic [COL_W-1:0]              col_cur;
    logic [ROW_W-1:0]              row_cur;
    logic [CMP_W-1:0]              wext;
    logic [CMP_W-1:0]              eff_width;
    logic                          wrap;
    logic                          emit;
    logic [9:0]                    csum;
    logic [20:0]                   gprod;
    logic [rgcc_pkg::GRAY_W-1:0]   gray;
    logic [CX_W-1:0]               cdiff;
    logic [RX_W-1:0]               rdiff;

    logic [LS_W-1:0]               lmem [MAX_WIDTH];
    logic [LS_W-1:0]               lmem_q_reg;
    logic [LS_W-1:0]               fwd_data_reg;
    logic                          fwd_hit_reg;
    logic [LS_W-1:0]               rd_eff;
    logic [LS_W-1:0]               wr_data;

    logic                          s1_valid_reg;
    logic                          s1_emit_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [rgcc_pkg::GRAY_W-1:0]   s1_gray_reg;
    logic [rgcc_pkg::COORD_W-1:0]  s1_ocol_reg;
    logic [rgcc_pkg::COORD_W-1:0]  s1_orow_reg;

    rgcc_pkg::column_t             column;
    rgcc_pkg::stage_ctrl_t         s1_ctrl;
    rgcc_pkg::stage_ctrl_t         s3_ctrl;
    logic [rgcc_pkg::GRAY_W-1:0]   conv_value;

    logic                          res_valid_reg;
    logic [rgcc_pkg::GRAY_W-1:0]   res_value_reg;
    logic [rgcc_pkg::COORD_W-1:0]  res_col_reg;
    logic [rgcc_pkg::COORD_W-1:0]  res_row_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= rgcc_pkg::IMAGE_WIDTH_RESET;
            ksel_reg  <= rgcc_pkg::KSEL_IDENTITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgcc_pkg::CFG_IMAGE_WIDTH:   width_reg <= cfg_data[rgcc_pkg::IWID_W-1:0];
                rgcc_pkg::CFG_KERNEL_SELECT: ksel_reg  <= cfg_data[rgcc_pkg::KSEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv       = !res_valid_reg || res.ready;
    assign acc       = pix.valid && adv;
    assign pix.ready = adv;

    assign col_cur = pix.frame_start ? '0 : col_reg;
    assign row_cur = pix.frame_start ? '0 : row_reg;
    assign emit    = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));

    assign wext = CMP_W'(width_reg);
    always_comb
    begin
        if (wext < CMP_W'(3))
        begin
            eff_width = CMP_W'(3);
        end
        else if (wext > CMP_W'(MAX_WIDTH))
        begin
            eff_width = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = wext;
        end
    end
    assign wrap = (CMP_W'(col_cur) + CMP_W'(1)) >= eff_width;

    // gray = (r + g + b) / 3
    assign csum  = {2'b00, pix.pixel_rgb565[15:11], 3'b000}
                 + {2'b00, pix.pixel_rgb565[10:5], 2'b00}
                 + {2'b00, pix.pixel_rgb565[4:0], 3'b000};
    assign gprod = {11'd0, csum} * {10'd0, rgcc_pkg::GRAY_RECIP};
    assign gray  = gprod[rgcc_pkg::GRAY_SHIFT +: rgcc_pkg::GRAY_W];

    assign cdiff = CX_W'(col_cur) - CX_W'(2);
    assign rdiff = RX_W'(row_cur) - RX_W'(2);

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            if (wrap)
            begin
                col_reg <= '0;
                if (row_cur < ROW_W'(MAX_HEIGHT - 1))
                begin
                    row_reg <= row_cur + ROW_W'(1);
                end
                else
                begin
                    row_reg <= row_cur;
                end
            end
            else
            begin
                col_reg <= col_cur + COL_W'(1);
                row_reg <= row_cur;
            end
        end
    end

    // line store, upper in high byte, middle in low byte
    assign rd_eff  = fwd_hit_reg ? fwd_data_reg : lmem_q_reg;
    assign wr_data = {rd_eff[rgcc_pkg::GRAY_W-1:0], s1_gray_reg};

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            lmem[s1_col_reg] <= wr_data;
        end
        if (acc)
        begin
            lmem_q_reg   <= lmem[col_cur];
            fwd_data_reg <= wr_data;
            s1_emit_reg  <= emit;
            s1_col_reg   <= col_cur;
            s1_gray_reg  <= gray;
            s1_ocol_reg  <= cdiff[rgcc_pkg::COORD_W-1:0];
            s1_orow_reg  <= rdiff[rgcc_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= acc;
            fwd_hit_reg  <= acc && s1_valid_reg && (s1_col_reg == col_cur);
        end
    end

    assign column.upper  = rd_eff[LS_W-1:rgcc_pkg::GRAY_W];
    assign column.middle = rd_eff[rgcc_pkg::GRAY_W-1:0];
    assign column.gray   = s1_gray_reg;

    assign s1_ctrl.valid   = s1_valid_reg && s1_emit_reg;
    assign s1_ctrl.out_col = s1_ocol_reg;
    assign s1_ctrl.out_row = s1_orow_reg;

    rgcc_conv u_conv (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .shift         (s1_valid_reg),
        .column        (column),
        .ctrl_in       (s1_ctrl),
        .kernel_select (ksel_reg),
        .ctrl_out      (s3_ctrl),
        .value         (conv_value)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_value_reg <= conv_value;
            res_col_reg   <= s3_ctrl.out_col;
            res_row_reg   <= s3_ctrl.out_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= s3_ctrl.valid;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.filtered_value = res_value_reg;
    assign res.out_col        = res_col_reg;
    assign res.out_row        = res_row_reg;

endmodule

`default_nettype wire
